[hdl/hll_wave_speed_estimate_macros.svh]
// Assertion macros used by hll_wave_speed_estimate
`ifndef HLL_WAVE_SPEED_ESTIMATE_MACROS_SVH
`define HLL_WAVE_SPEED_ESTIMATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define HWSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hwse: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define HWSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hwse: next-cycle check failed");

`endif

[hdl/hwse_pkg.sv]
// ----------------------------------------------------------------------------
// hwse_pkg
// Constants shared by the HLL wave speed estimate block.
// ----------------------------------------------------------------------------
package hwse_pkg;
	localparam int GAMMA_BITS  = 14;
	localparam int GAMMA_FRAC  = 12;
	localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 14'd6827;
endpackage

[hdl/hll_wave_speed_estimate.sv]
// ----------------------------------------------------------------------------
// hll_wave_speed_estimate
// HLL (Davis) signal speed estimate: per side c = sqrt(gamma*P/rho), then
// min(v - c) and max(v + c) over both sides, saturated.
// ----------------------------------------------------------------------------
// channel  handshake             payload
// in       in_valid / in_stall   left/right density, pressure, velocity
// out      out_valid / out_stall left_speed, right_speed, invalid_state
// cfg      cfg_valid / cfg_ready heat_capacity_ratio
//
// One request enters per cycle unless the output stalls. An entry register,
// QW = WORD_BITS + 2*FRAC_BITS + 1 restoring divider stages (one quotient
// bit each), RW = ceil(QW/2) square root stages (one root bit each) and an
// output register follow in that order. Reset clears the valid bits and
// loads gamma with five thirds. A stalled result freezes the whole pipeline.
// ----------------------------------------------------------------------------
`include "hll_wave_speed_estimate_macros.svh"

module hll_wave_speed_estimate #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hwse_pkg::GAMMA_BITS-1:0]     heat_capacity_ratio,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [WORD_BITS-2:0]                left_density,
	input  logic [WORD_BITS-2:0]                left_pressure,
	input  logic signed [WORD_BITS-1:0]         left_velocity,
	input  logic [WORD_BITS-2:0]                right_density,
	input  logic [WORD_BITS-2:0]                right_pressure,
	input  logic signed [WORD_BITS-1:0]         right_velocity,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [WORD_BITS-1:0]         left_speed,
	output logic signed [WORD_BITS-1:0]         right_speed,
	output logic                                invalid_state
);
	import hwse_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int SH  = 2*FRAC_BITS - GAMMA_FRAC;
	localparam int PW  = GAMMA_BITS + W - 1;
	localparam int QW  = PW + SH;
	localparam int RW  = (QW + 1) / 2;
	localparam int NP  = QW + RW;
	localparam int XW  = ((RW > W) ? RW : W) + 1;

	logic [GAMMA_BITS-1:0] gamma_q;
	logic                  adv;

	// sideband carried through every stage
	logic              vld_s [0:NP];
	logic              inv_s [0:NP];
	logic [W-1:0]      vel_s [0:1][0:NP];

	// divider stages
	logic [QW-1:0]     num_s [0:1][0:QW];
	logic [QW-1:0]     quo_s [0:1][0:QW];
	logic [W-2:0]      rem_s [0:1][0:QW];
	logic [W-2:0]      den_s [0:1][0:QW];

	// square root stages
	logic [2*RW-1:0]   rad_s  [0:1][0:RW];
	logic [RW:0]       srem_s [0:1][0:RW];
	logic [RW-1:0]     root_s [0:1][0:RW];

	logic              out_vld_q;
	logic [W-1:0]      lo_q, hi_q;
	logic              inv_q;

	assign cfg_ready = 1'b1;
	assign adv       = !(out_vld_q && out_stall);
	assign in_stall  = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (cfg_valid) begin
			gamma_q <= heat_capacity_ratio;
		end
	end

	// entry stage: gamma * P, aligned to 3F fraction bits so the quotient has 2F
	logic [W-2:0] rho_in [0:1];
	logic [W-2:0] prs_in [0:1];
	logic [W-1:0] vel_in [0:1];
	assign rho_in[0] = left_density;
	assign rho_in[1] = right_density;
	assign prs_in[0] = left_pressure;
	assign prs_in[1] = right_pressure;
	assign vel_in[0] = left_velocity;
	assign vel_in[1] = right_velocity;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s[0] <= (left_density == '0) || (right_density == '0);
		end
	end

	genvar s, k;
	generate
		for (s = 0; s < 2; s++) begin : g_side
			logic [PW-1:0] prod;
			assign prod = PW'(gamma_q) * PW'(prs_in[s]);

			always_ff @(posedge clk) begin
				if (adv) begin
					num_s[s][0] <= {prod, {SH{1'b0}}};
					quo_s[s][0] <= '0;
					rem_s[s][0] <= '0;
					den_s[s][0] <= rho_in[s];
					vel_s[s][0] <= vel_in[s];
				end
			end

			// restoring division, one quotient bit per stage
			for (k = 0; k < QW; k++) begin : g_div
				logic [W-1:0] tr;
				logic         ge;
				assign tr = {rem_s[s][k], num_s[s][k][QW-1]};
				assign ge = tr >= {1'b0, den_s[s][k]};
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_s[s][k+1] <= ge ? (W-1)'(tr - {1'b0, den_s[s][k]})
						                    : tr[W-2:0];
						quo_s[s][k+1] <= {quo_s[s][k][QW-2:0], ge};
						num_s[s][k+1] <= {num_s[s][k][QW-2:0], 1'b0};
						den_s[s][k+1] <= den_s[s][k];
					end
				end
			end

			assign rad_s[s][0]  = (2*RW)'(quo_s[s][QW]);
			assign srem_s[s][0] = '0;
			assign root_s[s][0] = '0;

			// digit-by-digit square root, one root bit per stage
			for (k = 0; k < RW; k++) begin : g_sqrt
				logic [RW+2:0] tr;
				logic [RW+2:0] trial;
				logic          ge;
				assign tr    = {srem_s[s][k], rad_s[s][k][2*RW-1 -: 2]};
				assign trial = {1'b0, root_s[s][k], 2'b01};
				assign ge    = tr >= trial;
				always_ff @(posedge clk) begin
					if (adv) begin
						srem_s[s][k+1] <= ge ? (RW+1)'(tr - trial) : tr[RW:0];
						root_s[s][k+1] <= {root_s[s][k][RW-2:0], ge};
						rad_s[s][k+1]  <= {rad_s[s][k][2*RW-3:0], 2'b00};
					end
				end
			end

			for (k = 0; k < NP; k++) begin : g_vel
				always_ff @(posedge clk) begin
					if (adv) begin
						vel_s[s][k+1] <= vel_s[s][k];
					end
				end
			end
		end

		for (k = 0; k < NP; k++) begin : g_band
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (adv) begin
					vld_s[k+1] <= vld_s[k];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					inv_s[k+1] <= inv_s[k];
				end
			end
		end
	endgenerate

	// final stage: saturate v -/+ c in offset binary, then min and max
	logic [W-1:0]  off0, off1;
	logic [XW-1:0] lx0, lx1, hx0, hx1;
	logic [W-1:0]  lo0, lo1, hi0, hi1, lo_n, hi_n;

	always_comb begin
		off0 = {~vel_s[0][NP][W-1], vel_s[0][NP][W-2:0]};
		off1 = {~vel_s[1][NP][W-1], vel_s[1][NP][W-2:0]};
		lx0  = XW'(off0) - XW'(root_s[0][RW]);
		lx1  = XW'(off1) - XW'(root_s[1][RW]);
		hx0  = XW'(off0) + XW'(root_s[0][RW]);
		hx1  = XW'(off1) + XW'(root_s[1][RW]);
		lo0  = lx0[XW-1] ? '0 : lx0[W-1:0];
		lo1  = lx1[XW-1] ? '0 : lx1[W-1:0];
		hi0  = (hx0 > XW'({W{1'b1}})) ? {W{1'b1}} : hx0[W-1:0];
		hi1  = (hx1 > XW'({W{1'b1}})) ? {W{1'b1}} : hx1[W-1:0];
		lo_n = (lo1 < lo0) ? lo1 : lo0;
		hi_n = (hi1 > hi0) ? hi1 : hi0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[NP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q <= inv_s[NP];
			lo_q  <= inv_s[NP] ? '0 : {~lo_n[W-1], lo_n[W-2:0]};
			hi_q  <= inv_s[NP] ? '0 : {~hi_n[W-1], hi_n[W-2:0]};
		end
	end

	assign out_valid     = out_vld_q;
	assign left_speed    = lo_q;
	assign right_speed   = hi_q;
	assign invalid_state = inv_q;

	`HWSE_ASSERT_NOW(a_invalid_zero, out_valid && invalid_state, (left_speed == '0) && (right_speed == '0))
	`HWSE_ASSERT_NOW(a_speed_order, out_valid && !invalid_state, left_speed <= right_speed)
	`HWSE_ASSERT_NEXT(a_div_to_sqrt, adv && vld_s[QW], vld_s[QW+1])
	`HWSE_ASSERT_NEXT(a_freeze, !adv, out_vld_q && $stable(lo_q) && $stable(hi_q))

endmodule
